// File: hdl/sha1mh_pkg.sv
// Shared types, constants and round functions for the SHA-1 message hasher.
// Used by sha1mh_front, sha1mh_core, sha1mh_back and sha1_message_hasher.
// No dependencies.
package sha1mh_pkg;

    typedef logic [31:0] word_t;

    localparam int WORD_COUNT  = 5;
    localparam int BLOCK_BYTES = 64;
    localparam int LENGTH_POS  = 56;
    localparam int ROUND_COUNT = 80;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    // H0 sits in the top word
    localparam logic [159:0] SHA1_IV = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    // One queued input item after classification
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } item_t;

    // Commands from the sequencer to the compression engine
    typedef struct packed {
        logic start;
        logic reinit;
    } core_ctrl_t;

    // Round phase: which 20-round quarter a round belongs to
    localparam logic [1:0] PH_CHOOSE = 2'd0;
    localparam logic [1:0] PH_PARITY = 2'd1;
    localparam logic [1:0] PH_MAJOR  = 2'd2;
    localparam logic [1:0] PH_LATE   = 2'd3;

    function automatic word_t round_f(logic [1:0] phase, word_t b, word_t c, word_t d);
        word_t f;
        case (phase)
            PH_CHOOSE: f = (b & c) | (~b & d);
            PH_MAJOR:  f = (b & c) | (b & d) | (c & d);
            default:   f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic word_t round_k(logic [1:0] phase);
        word_t k;
        case (phase)
            PH_CHOOSE: k = K0;
            PH_PARITY: k = K1;
            PH_MAJOR:  k = K2;
            default:   k = K3;
        endcase
        return k;
    endfunction

endpackage

// File: hdl/sha1mh_front.sv
// Front end of the SHA-1 hasher: takes stream transactions, drops empty items
// and queues the rest for the sequencer. Depends on sha1mh_pkg.
module sha1mh_front #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  logic              s_axis_tuser,
    input  logic              s_axis_tlast,
    output sha1mh_pkg::item_t item,
    output logic              item_ready,
    input  logic              item_pop
);
    import sha1mh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            queue_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign s_axis_tready = (count_reg != CNT_W'(DEPTH));
    // an item with neither a byte nor an end mark does nothing: drop it here
    assign push       = s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tlast);
    assign item_ready = (count_reg != '0);
    assign pop        = item_pop && item_ready;
    assign item       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= '{data: s_axis_tdata, valid: s_axis_tuser,
                                       last: s_axis_tlast};
        end
    end

endmodule

// File: hdl/sha1mh_core.sv
// SHA-1 compression engine: one round per cycle over a 16-word schedule window,
// then the chaining-word update. Depends on sha1mh_pkg.
module sha1mh_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha1mh_pkg::core_ctrl_t ctrl,
    input  logic [511:0]           block,
    output logic                   busy,
    output logic [159:0]           chain
);
    import sha1mh_pkg::*;

    logic        busy_reg;
    logic [6:0]  round_reg;
    word_t       chain_reg [WORD_COUNT];
    word_t       work_reg  [WORD_COUNT];
    word_t       sched_reg [16];
    logic [1:0]  phase;
    word_t       temp;
    word_t       sched_new;
    logic        finish;

    assign busy   = busy_reg;
    assign chain  = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3], chain_reg[4]};
    assign finish = (round_reg == 7'(ROUND_COUNT));

    always_comb
    begin
        if (round_reg < 7'd20)
            phase = PH_CHOOSE;
        else if (round_reg < 7'd40)
            phase = PH_PARITY;
        else if (round_reg < 7'd60)
            phase = PH_MAJOR;
        else
            phase = PH_LATE;
    end

    // sched_reg[0] is W(t); the new tail is W(t+16)
    assign sched_new = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];

    assign temp = {work_reg[0][26:0], work_reg[0][31:27]}
                + round_f(phase, work_reg[1], work_reg[2], work_reg[3])
                + work_reg[4] + sched_reg[0] + round_k(phase);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                chain_reg[i] <= SHA1_IV[159 - 32*i -: 32];
            end
        end
        else
        begin
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (finish)
                begin
                    busy_reg <= 1'b0;
                    for (int i = 0; i < WORD_COUNT; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
                else
                begin
                    round_reg <= round_reg + 1'b1;
                end
            end
            if (ctrl.reinit)
            begin
                for (int i = 0; i < WORD_COUNT; i++)
                begin
                    chain_reg[i] <= SHA1_IV[159 - 32*i -: 32];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
            for (int i = 0; i < 16; i++)
            begin
                sched_reg[i] <= block[511 - 32*i -: 32];
            end
        end
        else if (busy_reg && !finish)
        begin
            work_reg[4] <= work_reg[3];
            work_reg[3] <= work_reg[2];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
            work_reg[1] <= work_reg[0];
            work_reg[0] <= temp;
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= {sched_new[30:0], sched_new[31]};
        end
    end

endmodule

// File: hdl/sha1mh_back.sv
// Back end of the SHA-1 hasher: packs bytes into the block buffer, pads,
// drives the compression engine and streams out the digest. Depends on sha1mh_pkg.
module sha1mh_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha1mh_pkg::item_t      item,
    input  logic                   item_ready,
    output logic                   item_pop,
    output sha1mh_pkg::core_ctrl_t core_ctrl,
    output logic [511:0]           block,
    input  logic                   core_busy,
    input  logic [159:0]           chain,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [39:0]            m_axis_tdata,
    output logic                   m_axis_tlast
);
    import sha1mh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FULL  = 3'd1;
    localparam logic [2:0] S_PAD80 = 3'd2;
    localparam logic [2:0] S_PADZ  = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;
    localparam logic [2:0] S_DWAIT = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]   state_reg, state_next;
    logic [6:0]   pos_reg, pos_next;
    logic [63:0]  count_reg, count_next;
    logic [511:0] buf_reg, buf_next;
    logic         last_reg, last_next;
    logic [159:0] digest_reg, digest_next;
    logic [2:0]   word_reg, word_next;
    logic         out_valid_reg;
    word_t        out_word_reg;
    logic [2:0]   out_num_reg;
    logic         out_last_reg;
    logic         out_free;
    logic         out_load;
    logic         push;
    logic [7:0]   push_byte;

    assign block         = buf_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_num_reg, out_word_reg};
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        buf_next    = buf_reg;
        last_next   = last_reg;
        digest_next = digest_reg;
        word_next   = word_reg;
        item_pop    = 1'b0;
        core_ctrl   = '{start: 1'b0, reinit: 1'b0};
        out_load    = 1'b0;
        push        = 1'b0;
        push_byte   = 8'h00;

        case (state_reg)
            S_IDLE:
            begin
                if (item_ready)
                begin
                    item_pop  = 1'b1;
                    last_next = item.last;
                    if (item.valid)
                    begin
                        push       = 1'b1;
                        push_byte  = item.data;
                        count_next = count_reg + 64'd8;
                        state_next = S_FULL;
                    end
                    else
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_FULL:
            begin
                if (pos_reg == 7'(BLOCK_BYTES))
                begin
                    if (!core_busy)
                    begin
                        core_ctrl.start = 1'b1;
                        pos_next        = '0;
                        state_next      = last_reg ? S_PAD80 : S_IDLE;
                    end
                end
                else
                begin
                    state_next = last_reg ? S_PAD80 : S_IDLE;
                end
            end
            S_PAD80:
            begin
                push       = 1'b1;
                push_byte  = PAD_MARK;
                state_next = S_PADZ;
            end
            S_PADZ:
            begin
                if (pos_reg == 7'(BLOCK_BYTES))
                begin
                    if (!core_busy)
                    begin
                        core_ctrl.start = 1'b1;
                        pos_next        = '0;
                    end
                end
                else if (pos_reg == 7'(LENGTH_POS))
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            S_LEN:
            begin
                // append the 64-bit length in one step
                buf_next   = {buf_reg[447:0], count_reg};
                pos_next   = 7'(BLOCK_BYTES);
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (!core_busy)
                begin
                    core_ctrl.start = 1'b1;
                    pos_next        = '0;
                    count_next      = '0;
                    state_next      = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (!core_busy)
                begin
                    digest_next      = chain;
                    core_ctrl.reinit = 1'b1;
                    word_next        = '0;
                    state_next       = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    digest_next = {digest_reg[127:0], 32'h0};
                    word_next   = word_reg + 1'b1;
                    if (word_reg == 3'(WORD_COUNT - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push)
        begin
            buf_next = {buf_reg[503:0], push_byte};
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            word_reg  <= word_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg    <= buf_next;
        digest_reg <= digest_next;
        if (out_load)
        begin
            out_word_reg <= digest_reg[159:128];
            out_num_reg  <= word_reg;
            out_last_reg <= (word_reg == 3'(WORD_COUNT - 1));
        end
    end

endmodule

// File: hdl/sha1_message_hasher.sv
// The sequencer takes each message byte through S_IDLE and then S_FULL; the compression
// of a full block overlaps the packing of the next one.
// After the end-of-message transaction the sequencer pads, appends the length and runs the
// final compression (two if padding spills into a second block), then emits the digest;
// earlier queued items add their own time. Digest words follow 1 per cycle while the sink is ready.
// Reset: asynchronous, active low; restores the initial chaining words, empties the queue.
module sha1_message_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    // digest stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_number, rest zero
    output logic        m_axis_tlast    // last_word
);
    import sha1mh_pkg::*;

    // Front: classify each transaction, drop items that carry neither a byte
    // nor an end mark, and hold the rest in a short queue.
    item_t        item;
    logic         item_ready;
    logic         item_pop;
    // Back: byte packing, padding sequencer and digest output register.
    core_ctrl_t   core_ctrl;
    logic [511:0] block;
    logic         core_busy;
    logic [159:0] chain;

    sha1mh_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .item         (item),
        .item_ready   (item_ready),
        .item_pop     (item_pop)
    );

    sha1mh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_ready   (item_ready),
        .item_pop     (item_pop),
        .core_ctrl    (core_ctrl),
        .block        (block),
        .core_busy    (core_busy),
        .chain        (chain),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Compression: one round per cycle, chaining words held here between blocks.
    sha1mh_core u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (core_ctrl),
        .block(block),
        .busy (core_busy),
        .chain(chain)
    );

`ifndef NO_ASSERTIONS
    // A new block never lands on a compression in flight.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        core_ctrl.start |-> !core_busy)
        else $error("compression started while engine busy");

    // A started compression shows as busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_ctrl.start |=> core_busy)
        else $error("engine did not go busy after start");

    // Chaining words are reloaded only after the digest is final.
    a_reinit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        core_ctrl.reinit |-> (!core_busy && !core_ctrl.start))
        else $error("chaining words reinitialized during compression");

    // The end-of-digest mark comes only with the final word number.
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[34:32] == 3'(WORD_COUNT - 1)))
        else $error("last_word on a word other than the final one");
`endif

endmodule
